### rtl/prvc_pkg.sv
// Shared constants, types and channel table for the regulator voltage control block.
package prvc_pkg;

    // Defaults for the top-level parameters
    localparam int NUM_CHANNELS_DEF = 10;
    localparam int CODE_BITS_DEF    = 8;

    // Fixed field widths
    localparam int FUNC_W     = 3;
    localparam int CHAN_W     = 4;
    localparam int VOLT_IN_W  = 22;
    localparam int INDEX_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int SEL_W      = 9;
    localparam int VOLT_OUT_W = 25;
    localparam int STEP_W     = 17;
    localparam int SHIFT_W    = 3;
    localparam int MASK_W     = 8;

    // Rows present in the channel table
    localparam int TABLE_ROWS = 10;

    // APB configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_SUSPENDED = 1'b0;

    // Every step is 3125 uV times a power of two
    localparam int DIV_BASE    = 3125;
    localparam int DIV_IN_W    = 20;
    localparam int RECIP_SHIFT = 32;
    localparam int RECIP_W     = 21;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << RECIP_SHIFT) + 64'(DIV_BASE) - 64'd1) / 64'(DIV_BASE);
    localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_FULL);

    // Buck channels
    localparam logic [VOLT_IN_W-1:0] BUCK_MIN_UV     = 22'd600000;
    localparam logic [VOLT_IN_W-1:0] BUCK_MAX_UV     = 22'd3600000;
    localparam logic [STEP_W-1:0]    BUCK_STEP_UV    = 17'd12500;
    localparam logic [SHIFT_W-1:0]   BUCK_STEP_SHIFT = 3'd2;
    localparam logic [MASK_W-1:0]    BUCK_MASK       = 8'hff;

    // Small LDO channel
    localparam logic [VOLT_IN_W-1:0] SLDO_MIN_UV     = 22'd700000;
    localparam logic [VOLT_IN_W-1:0] SLDO_MAX_UV     = 22'd3800000;
    localparam logic [STEP_W-1:0]    SLDO_STEP_UV    = 17'd100000;
    localparam logic [SHIFT_W-1:0]   SLDO_STEP_SHIFT = 3'd5;
    localparam logic [MASK_W-1:0]    SLDO_MASK       = 8'h1f;

    // LDO channels
    localparam logic [VOLT_IN_W-1:0] LDO_MIN_UV      = 22'd700000;
    localparam logic [VOLT_IN_W-1:0] LDO_MAX_UV      = 22'd3400000;
    localparam logic [STEP_W-1:0]    LDO_STEP_UV     = 17'd25000;
    localparam logic [SHIFT_W-1:0]   LDO_STEP_SHIFT  = 3'd3;
    localparam logic [MASK_W-1:0]    LDO_MASK        = 8'h7f;

    typedef enum logic [FUNC_W-1:0] {
        FN_SET     = 3'd0,
        FN_GET     = 3'd1,
        FN_LIST    = 3'd2,
        FN_ENABLE  = 3'd3,
        FN_DISABLE = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_BUSY  = 2'd2,
        ST_BADCH = 2'd3
    } status_t;

    typedef struct packed {
        logic [VOLT_IN_W-1:0] lo_uv;
        logic [VOLT_IN_W-1:0] hi_uv;
        logic [STEP_W-1:0]    step_uv;
        logic [SHIFT_W-1:0]   step_shift;
        logic [MASK_W-1:0]    mask;
    } chan_row_t;

    typedef struct packed {
        logic [FUNC_W-1:0]    func;
        logic [CHAN_W-1:0]    channel;
        logic [VOLT_IN_W-1:0] min_volt;
        logic [VOLT_IN_W-1:0] max_volt;
        logic [INDEX_W-1:0]   list_index;
    } req_t;

    typedef struct packed {
        status_t               status;
        logic [SEL_W-1:0]      selector;
        logic [VOLT_OUT_W-1:0] voltage;
        logic                  enabled;
    } rsp_t;

    // Channel state update request
    typedef struct packed {
        logic code_we;
        logic en_we;
        logic en_val;
    } upd_t;

    // Look up the fixed row of a channel
    function automatic chan_row_t chan_row_lookup(input logic [CHAN_W-1:0] ch);
        chan_row_t row;
        case (ch) inside
            [4'd0:4'd2]:
            begin
                row = '{lo_uv: BUCK_MIN_UV, hi_uv: BUCK_MAX_UV, step_uv: BUCK_STEP_UV,
                        step_shift: BUCK_STEP_SHIFT, mask: BUCK_MASK};
            end
            4'd3:
            begin
                row = '{lo_uv: SLDO_MIN_UV, hi_uv: SLDO_MAX_UV, step_uv: SLDO_STEP_UV,
                        step_shift: SLDO_STEP_SHIFT, mask: SLDO_MASK};
            end
            default:
            begin
                row = '{lo_uv: LDO_MIN_UV, hi_uv: LDO_MAX_UV, step_uv: LDO_STEP_UV,
                        step_shift: LDO_STEP_SHIFT, mask: LDO_MASK};
            end
        endcase
        return row;
    endfunction

endpackage

### rtl/prvc_req_if.sv
// Request channel interface: valid/ready handshake with the request payload.
interface prvc_req_if
    import prvc_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [FUNC_W-1:0]    func;
    logic [CHAN_W-1:0]    channel;
    logic [VOLT_IN_W-1:0] min_volt;
    logic [VOLT_IN_W-1:0] max_volt;
    logic [INDEX_W-1:0]   list_index;

    modport source (
        output valid, func, channel, min_volt, max_volt, list_index,
        input  ready
    );

    modport sink (
        input  valid, func, channel, min_volt, max_volt, list_index,
        output ready
    );
endinterface

### rtl/prvc_rsp_if.sv
// Result channel interface: valid/ready handshake with the result payload.
interface prvc_rsp_if
    import prvc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [SEL_W-1:0]      selector;
    logic [VOLT_OUT_W-1:0] voltage;
    logic                  enabled;

    modport source (
        output valid, status, selector, voltage, enabled,
        input  ready
    );

    modport sink (
        input  valid, status, selector, voltage, enabled,
        output ready
    );
endinterface

### rtl/prvc_cfg_regs.sv
// APB configuration register holding the suspended flag.
module prvc_cfg_regs
    import prvc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic                  suspended
);

    logic reg_sel;
    logic wr_en;
    logic suspended_reg;
    logic suspended_next;

    // Register index is the word address
    assign reg_sel = paddr[APB_ADDR_W-1];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    // Update the flag on a write transaction to its address
    always_comb
    begin
        suspended_next = suspended_reg;
        if (wr_en && (reg_sel == REG_SUSPENDED))
        begin
            suspended_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            suspended_reg <= 1'b0;
        end
        else
        begin
            suspended_reg <= suspended_next;
        end
    end

    // Read back the flag, zero elsewhere
    assign prdata    = (reg_sel == REG_SUSPENDED) ? APB_DATA_W'(suspended_reg) : '0;
    assign suspended = suspended_reg;

endmodule

### rtl/prvc_chan_state.sv
// Per-channel enable flags and stored voltage codes.
module prvc_chan_state
    import prvc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [CHAN_W-1:0]    channel,
    input  logic                 wr_en,
    input  upd_t                 upd,
    input  logic [CODE_BITS-1:0] code_new,
    output logic                 en_cur,
    output logic [CODE_BITS-1:0] code_cur
);

    logic                 en_reg   [NUM_CHANNELS];
    logic [CODE_BITS-1:0] code_reg [NUM_CHANNELS];

    // Select the addressed channel
    always_comb
    begin
        en_cur   = 1'b0;
        code_cur = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (channel == CHAN_W'(i))
            begin
                en_cur   = en_reg[i];
                code_cur = code_reg[i];
            end
        end
    end

    // Write the addressed channel when the step retires
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                en_reg[i]   <= 1'b0;
                code_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (wr_en && (channel == CHAN_W'(i)))
                begin
                    if (upd.en_we)
                    begin
                        en_reg[i] <= upd.en_val;
                    end
                    if (upd.code_we)
                    begin
                        code_reg[i] <= code_new;
                    end
                end
            end
        end
    end

endmodule

### rtl/prvc_exec.sv
// Request evaluation: range check, selector division and voltage calculation.
module prvc_exec
    import prvc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF
) (
    input  req_t                 req,
    input  logic                 suspended,
    input  logic                 en_cur,
    input  logic [CODE_BITS-1:0] code_cur,
    output rsp_t                 rsp,
    output upd_t                 upd,
    output logic [CODE_BITS-1:0] code_new
);

    chan_row_t                     row;
    logic                          ch_ok;
    logic                          range_bad;
    logic [VOLT_IN_W-1:0]          diff;
    logic [DIV_IN_W-1:0]           div_in;
    logic [DIV_IN_W+RECIP_W-1:0]   prod;
    logic [SEL_W-1:0]              quot;
    logic [INDEX_W-1:0]            mul_op;
    logic [VOLT_OUT_W-1:0]         scaled;
    logic [VOLT_OUT_W-1:0]         read_volt;

    // Channel row and validity
    assign row   = chan_row_lookup(req.channel);
    assign ch_ok = ({1'b0, req.channel} < (CHAN_W+1)'(NUM_CHANNELS))
                && (req.channel < CHAN_W'(TABLE_ROWS));

    // Selector: strip the power of two, then divide by the base step by reciprocal
    assign diff      = req.min_volt - row.lo_uv;
    assign div_in    = DIV_IN_W'(diff >> row.step_shift);
    assign prod      = div_in * RECIP_MULT;
    assign quot      = prod[RECIP_SHIFT +: SEL_W];
    assign range_bad = (req.min_volt < row.lo_uv) || (req.max_volt > row.hi_uv);
    assign code_new  = CODE_BITS'(quot[MASK_W-1:0] & row.mask);

    // Voltage of the stored code or of the listed index
    assign mul_op    = (req.func == FN_GET) ? INDEX_W'(code_cur) : req.list_index;
    assign scaled    = VOLT_OUT_W'(mul_op) * VOLT_OUT_W'(row.step_uv);
    assign read_volt = VOLT_OUT_W'(row.lo_uv) + scaled;

    // Decode the function
    always_comb
    begin
        rsp.status   = ST_OK;
        rsp.selector = '0;
        rsp.voltage  = '0;
        rsp.enabled  = en_cur;
        upd          = '0;
        if (!ch_ok)
        begin
            rsp.status  = ST_BADCH;
            rsp.enabled = 1'b0;
        end
        else
        begin
            case (req.func)
                FN_SET:
                begin
                    if (suspended)
                    begin
                        rsp.status = ST_BUSY;
                    end
                    else if (range_bad)
                    begin
                        rsp.status = ST_RANGE;
                    end
                    else
                    begin
                        rsp.selector = quot;
                        upd.code_we  = 1'b1;
                    end
                end
                FN_GET, FN_LIST:
                begin
                    rsp.voltage = read_volt;
                end
                FN_ENABLE:
                begin
                    upd.en_we   = 1'b1;
                    upd.en_val  = 1'b1;
                    rsp.enabled = 1'b1;
                end
                FN_DISABLE:
                begin
                    upd.en_we   = 1'b1;
                    upd.en_val  = 1'b0;
                    rsp.enabled = 1'b0;
                end
                default:
                begin
                    rsp.status = ST_OK;
                end
            endcase
        end
    end

endmodule

### rtl/pmic_regulator_voltage_control.sv
// An accepted request is held in the request register and evaluated there; its result
// loads into the result register. Throughput: one request per cycle unless the result
// stalls; all evaluation sits between the two registers, and channel state is written as
// the result loads. A stalled result holds a full request register; an empty one fills.
// Reset (rst_n, asynchronous): clears suspended, all enable flags, all voltage codes
// and both valid flags; no clearing pass is needed.
module pmic_regulator_voltage_control
    import prvc_pkg::*;
#(
    parameter int NUM_CHANNELS = NUM_CHANNELS_DEF,
    parameter int CODE_BITS    = CODE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    prvc_req_if.sink              req,
    prvc_rsp_if.source            rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic                 suspended;
    logic                 advance;
    logic                 req_take;
    logic                 req_valid_reg;
    logic                 req_valid_next;
    logic                 rsp_valid_reg;
    logic                 rsp_valid_next;
    req_t                 req_in;
    req_t                 req_reg;
    rsp_t                 rsp_comb;
    rsp_t                 rsp_reg;
    upd_t                 upd;
    logic                 en_cur;
    logic [CODE_BITS-1:0] code_cur;
    logic [CODE_BITS-1:0] code_new;

    // Configuration register
    prvc_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .suspended (suspended)
    );

    // Flow control: the result register frees when empty or taken
    assign advance   = !rsp_valid_reg || rsp.ready;
    assign req.ready = !req_valid_reg || advance;
    assign req_take  = req.valid && req.ready;

    assign req_in = '{func: req.func, channel: req.channel, min_volt: req.min_volt,
                      max_volt: req.max_volt, list_index: req.list_index};

    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (req_take)
        begin
            req_valid_next = 1'b1;
        end
        else if (advance)
        begin
            req_valid_next = 1'b0;
        end
        rsp_valid_next = advance ? req_valid_reg : rsp_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Capture the request and the result payloads
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            req_reg <= req_in;
        end
        if (advance && req_valid_reg)
        begin
            rsp_reg <= rsp_comb;
        end
    end

    // Channel state, written as the result register loads
    prvc_chan_state #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CODE_BITS    (CODE_BITS)
    ) u_chan_state (
        .clk      (clk),
        .rst_n    (rst_n),
        .channel  (req_reg.channel),
        .wr_en    (advance && req_valid_reg),
        .upd      (upd),
        .code_new (code_new),
        .en_cur   (en_cur),
        .code_cur (code_cur)
    );

    // Evaluate the held request
    prvc_exec #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .CODE_BITS    (CODE_BITS)
    ) u_exec (
        .req       (req_reg),
        .suspended (suspended),
        .en_cur    (en_cur),
        .code_cur  (code_cur),
        .rsp       (rsp_comb),
        .upd       (upd),
        .code_new  (code_new)
    );

    // Drive the result channel
    assign rsp.valid    = rsp_valid_reg;
    assign rsp.status   = rsp_reg.status;
    assign rsp.selector = rsp_reg.selector;
    assign rsp.voltage  = rsp_reg.voltage;
    assign rsp.enabled  = rsp_reg.enabled;

    // A bad channel reports nothing else
    a_badch_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.status == ST_BADCH)
        |-> (rsp_reg.selector == '0) && (rsp_reg.voltage == '0) && !rsp_reg.enabled)
        else $error("bad channel result carries data");

    // A selector is reported only by an accepted set
    a_sel_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.selector != '0) |-> (rsp_reg.status == ST_OK))
        else $error("selector reported with non-ok status");

    // A request held back by a stalled result must not change
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !advance |=> req_valid_reg && $stable(req_reg))
        else $error("held request lost or changed");

    // An enable on a good channel reports the channel enabled
    a_enable_seen: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && advance && (req_reg.func == FN_ENABLE)
        && (rsp_comb.status != ST_BADCH)
        |=> rsp_valid_reg && rsp_reg.enabled)
        else $error("enable not reflected in result");

endmodule
